// File: hdl/lps_pkg.sv
package lps_pkg;

    // Field widths of the item and result transactions and of the limit register.
    localparam int NUM_W     = 14;
    localparam int CFG_W     = 15;
    localparam int CNT_OUT_W = 12;

    // Defaults for the top-level parameters.
    localparam int MAX_N_DEF      = 16384;
    localparam int MAX_PRIMES_DEF = 2048;

    // Smallest number that can be prime.
    localparam int MIN_PRIME = 2;

    // Width of the run tag kept in every bitmap entry.
    localparam int EPOCH_W = 4;

    // Remainder unit: quotient bits retired per cycle.
    localparam int DIV_BITS = 2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index (paddr[2]) of the limit register.
    localparam logic REG_LIMIT = 1'b0;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 15'd10000;

    // Control into and status out of the remainder unit.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
    } rem_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_sts_t;

endpackage

// File: hdl/lps_ram.sv
module lps_ram #(
    parameter int DEPTH = lps_pkg::MAX_PRIMES_DEF,
    parameter int WIDTH = lps_pkg::NUM_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/lps_rem.sv
module lps_rem (
    input  logic             aclk,
    input  logic             aresetn,
    input  lps_pkg::rem_ctl_t ctl,
    output lps_pkg::rem_sts_t sts
);

    localparam int STEPS = lps_pkg::NUM_W / lps_pkg::DIV_BITS;
    localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [SC_W-1:0]           cnt_reg, cnt_next;
    logic [lps_pkg::NUM_W-1:0] dvd_reg, dvd_next;
    logic [lps_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [lps_pkg::NUM_W-1:0] dvs_reg, dvs_next;
    logic [lps_pkg::NUM_W-1:0] step_rem;
    logic [lps_pkg::NUM_W-1:0] step_dvd;

    // Restoring division, a few quotient bits per cycle; only the remainder is kept.
    always_comb begin
        logic [lps_pkg::NUM_W:0]   t;
        logic [lps_pkg::NUM_W-1:0] r;
        logic [lps_pkg::NUM_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < lps_pkg::DIV_BITS; i++) begin
            t = {r, d[lps_pkg::NUM_W-1]};
            if (t >= {1'b0, dvs_reg}) begin
                t = t - {1'b0, dvs_reg};
            end
            r = t[lps_pkg::NUM_W-1:0];
            d = {d[lps_pkg::NUM_W-2:0], 1'b0};
        end
        step_rem = r;
        step_dvd = d;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            dvd_next  = ctl.dividend;
            rem_next  = '0;
            dvs_next  = ctl.divisor;
        end else if (busy_reg) begin
            dvd_next = step_dvd;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SC_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

endmodule

// File: hdl/linear_prime_sieve_unit.sv
// A number outside the range goes straight to the result register; otherwise the time it
// takes grows with each stored prime tested for divisibility.
// One item is in flight at a time; the next transaction can be taken in the cycle after the result
// is loaded. The remainder unit retires two quotient bits per cycle for each stored prime tested.
// Reset (aresetn, synchronous, active low) starts a clearing pass over the bitmap memory; the
// same pass repeats on every 15th new run, when the run tag wraps.
module linear_prime_sieve_unit #(
    parameter int MAX_N      = lps_pkg::MAX_N_DEF,
    parameter int MAX_PRIMES = lps_pkg::MAX_PRIMES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Item channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lps_pkg::NUM_W-1:0]         s_number,
    input  logic                              s_first,

    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lps_pkg::NUM_W-1:0]         m_value,
    output logic                              m_is_prime,
    output logic [lps_pkg::CNT_OUT_W-1:0]     m_prime_count,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lps_pkg::PADDR_W-1:0]       paddr,
    input  logic [lps_pkg::PDATA_W-1:0]       pwdata,
    output logic [lps_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    // Bitmap address width, prime list address width and prime count width.
    localparam int AW     = $clog2(MAX_N);
    localparam int PAW    = $clog2(MAX_PRIMES);
    localparam int CW     = $clog2(MAX_PRIMES + 1);
    localparam int PROD_W = 2 * lps_pkg::NUM_W;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,  // sweep the bitmap memory back to tag zero
        S_IDLE  = 9'b000000010,  // wait for an item transaction
        S_READ  = 9'b000000100,  // range check, read the bitmap entry of the number
        S_CHECK = 9'b000001000,  // primality from the tag, append to the prime list
        S_PREAD = 9'b000010000,  // read the next stored prime
        S_MUL   = 9'b000100000,  // form number * prime, start the remainder unit
        S_CMP   = 9'b001000000,  // limit check and marking write
        S_DIV   = 9'b010000000,  // wait for number mod prime
        S_FIN   = 9'b100000000   // load the result register
    } state_t;

    state_t                          state_reg, state_next;
    logic [lps_pkg::CFG_W-1:0]       limit_reg, limit_next;
    logic [lps_pkg::EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic                            go_reg, go_next;
    logic [lps_pkg::NUM_W-1:0]       num_reg, num_next;
    logic                            prime_reg, prime_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   j_reg, j_next;
    logic [lps_pkg::NUM_W-1:0]       p_reg, p_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;

    logic                            m_valid_reg, m_valid_next;
    logic [lps_pkg::NUM_W-1:0]       m_value_reg, m_value_next;
    logic                            m_is_prime_reg, m_is_prime_next;
    logic [CW-1:0]                   m_count_reg, m_count_next;

    logic [lps_pkg::CFG_W-1:0]       eff_lim;
    logic                            in_range;
    logic [AW+lps_pkg::NUM_W-1:0]    num_ext;
    logic [CW-1:0]                   cnt_after;
    logic [CW+lps_pkg::CNT_OUT_W-1:0] cnt_ext;
    logic                            cfg_wr;

    // Bitmap memory: each entry holds the run tag of the run that marked it composite.
    logic                            map_we;
    logic [AW-1:0]                   map_waddr;
    logic [lps_pkg::EPOCH_W-1:0]     map_wdata;
    logic                            map_re;
    logic [lps_pkg::EPOCH_W-1:0]     map_rdata;

    // Prime list memory.
    logic                            pl_we;
    logic                            pl_re;
    logic [lps_pkg::NUM_W-1:0]       pl_rdata;

    lps_pkg::rem_ctl_t               rem_ctl;
    lps_pkg::rem_sts_t               rem_sts;

    // ------------------------------------------------------------------
    // Configuration. The limit is clamped to the bitmap depth; the clamped
    // value fits the register width for the default depth, which is below
    // the largest value that the register can hold.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        limit_next = limit_reg;
        if (cfg_wr && (paddr[2] == lps_pkg::REG_LIMIT)) begin
            limit_next = pwdata[lps_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == lps_pkg::REG_LIMIT) begin
            prdata = lps_pkg::PDATA_W'(limit_reg);
        end
    end

    always_comb begin
        if (32'(limit_reg) > MAX_N) begin
            eff_lim = lps_pkg::CFG_W'(MAX_N);
        end else begin
            eff_lim = limit_reg;
        end
    end

    // A number takes part only when it lies in [2, limit), with the limit clamped to MAX_N.
    assign in_range = (num_reg >= lps_pkg::NUM_W'(lps_pkg::MIN_PRIME))
                   && ({1'b0, num_reg} < eff_lim);
    assign num_ext  = {{AW{1'b0}}, num_reg};

    // Prime count after a possible append in S_CHECK: a number whose tag does not
    // match the current run is prime, and it is stored while the list has room.
    always_comb begin
        cnt_after = count_reg;
        if ((map_rdata != epoch_reg) && (count_reg < CW'(MAX_PRIMES))) begin
            cnt_after = count_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. One item is in flight at a time, so every marking write of
    // an item lands before the next item's bitmap read and no forwarding is
    // needed. A new run advances the run tag, or sweeps the memory once all
    // tags are used up; entries with an older tag read as clear.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        clr_next     = clr_reg;
        go_next      = go_reg;
        num_next     = num_reg;
        prime_next   = prime_reg;
        count_next   = count_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        prod_next    = prod_reg;
        map_we       = 1'b0;
        map_waddr    = num_ext[AW-1:0];
        map_wdata    = epoch_reg;
        map_re       = 1'b0;
        pl_we        = 1'b0;
        pl_re        = 1'b0;
        rem_ctl      = '{start: 1'b0, dividend: num_reg, divisor: pl_rdata};
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_is_prime_next = m_is_prime_reg;
        m_count_next    = m_count_reg;

        case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_N - 1)) begin
                    epoch_next = lps_pkg::EPOCH_W'(1);
                    go_next    = 1'b0;
                    state_next = go_reg ? S_READ : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    num_next   = s_number;
                    prime_next = 1'b0;
                    state_next = S_READ;
                    if (s_first) begin
                        count_next = '0;
                        if (epoch_reg == {lps_pkg::EPOCH_W{1'b1}}) begin
                            // All tags used up: sweep the memory before this item.
                            clr_next   = '0;
                            go_next    = 1'b1;
                            state_next = S_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                if (in_range) begin
                    map_re     = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CHECK: begin
                prime_next = (map_rdata != epoch_reg);
                pl_we      = (cnt_after != count_reg);
                count_next = cnt_after;
                j_next     = '0;
                state_next = (cnt_after != '0) ? S_PREAD : S_FIN;
            end
            S_PREAD: begin
                pl_re      = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                p_next        = pl_rdata;
                prod_next     = PROD_W'(num_reg) * PROD_W'(pl_rdata);
                rem_ctl.start = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP: begin
                if (prod_reg >= PROD_W'(eff_lim)) begin
                    state_next = S_FIN;
                end else begin
                    map_we     = 1'b1;
                    map_waddr  = prod_reg[AW-1:0];
                    state_next = (p_reg == '0) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (rem_sts.done) begin
                    if (rem_sts.zero) begin
                        // Smallest prime factor reached: stop marking.
                        state_next = S_FIN;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ((j_reg + 1'b1) < count_reg) ? S_PREAD : S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_value_next    = num_reg;
                    m_is_prime_next = prime_reg;
                    m_count_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            limit_reg   <= lps_pkg::LIMIT_RESET;
            epoch_reg   <= lps_pkg::EPOCH_W'(1);
            clr_reg     <= '0;
            go_reg      <= 1'b0;
            count_reg   <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            epoch_reg   <= epoch_next;
            clr_reg     <= clr_next;
            go_reg      <= go_next;
            count_reg   <= count_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg        <= num_next;
        prime_reg      <= prime_next;
        p_reg          <= p_next;
        prod_reg       <= prod_next;
        m_value_reg    <= m_value_next;
        m_is_prime_reg <= m_is_prime_next;
        m_count_reg    <= m_count_next;
    end

    // ------------------------------------------------------------------
    // Memories and the remainder unit.
    // ------------------------------------------------------------------
    lps_ram #(
        .DEPTH (MAX_N),
        .WIDTH (lps_pkg::EPOCH_W)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (num_ext[AW-1:0]),
        .rdata (map_rdata)
    );

    lps_ram #(
        .DEPTH (MAX_PRIMES),
        .WIDTH (lps_pkg::NUM_W)
    ) u_plist (
        .aclk  (aclk),
        .we    (pl_we),
        .waddr (count_reg[PAW-1:0]),
        .wdata (num_reg),
        .re    (pl_re),
        .raddr (j_reg[PAW-1:0]),
        .rdata (pl_rdata)
    );

    lps_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rem_ctl),
        .sts     (rem_sts)
    );

    // ------------------------------------------------------------------
    // Outputs.
    // ------------------------------------------------------------------
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_is_prime    = m_is_prime_reg;
    assign cnt_ext       = {{lps_pkg::CNT_OUT_W{1'b0}}, m_count_reg};
    assign m_prime_count = cnt_ext[lps_pkg::CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    // The prime count never passes the capacity of the prime list.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PRIMES))
        else $error("prime count exceeds the prime list capacity");

    // A stored prime is only read at an index that has been written in this run.
    a_read_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PREAD) |-> (j_reg < count_reg))
        else $error("prime list read beyond the current count");

    // A prime reported on the result channel is at least two.
    a_prime_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_is_prime_reg) |-> (m_value_reg >= lps_pkg::NUM_W'(lps_pkg::MIN_PRIME)))
        else $error("result reports a number below two as prime");

    // The bitmap is never marked while the clearing pass owns the write port.
    a_mark_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (map_we && (map_wdata != '0)) |-> (state_reg == S_CMP))
        else $error("bitmap marked outside the marking step");
`endif

endmodule
